// ----- src/lhm_pkg.sv -----
// ----------------------------------------------------------------------------
// lhm_pkg: link health monitor shared definitions
// Default window sizes, configuration register indexes, reset values of the
// grading thresholds and the quality grade codes.
// ----------------------------------------------------------------------------
package lhm_pkg;

  // default window depths
  localparam int unsigned LATENCY_WINDOW_DEF = 8;
  localparam int unsigned LOSS_WINDOW_DEF    = 32;

  // field widths fixed by the interface
  localparam int unsigned LAT_W  = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned LOSS_W = 17;
  localparam int unsigned FRAC_W = 16;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_EXCELLENT = 2'd0;
  localparam logic [IDX_W-1:0] REG_GOOD      = 2'd1;
  localparam logic [IDX_W-1:0] REG_FAIR      = 2'd2;

  // threshold reset values in ms
  localparam logic [CFG_W-1:0] EXCELLENT_RST = 16'd50;
  localparam logic [CFG_W-1:0] GOOD_RST      = 16'd100;
  localparam logic [CFG_W-1:0] FAIR_RST      = 16'd200;

  // quality grades
  localparam logic [1:0] QUAL_EXCELLENT = 2'd0;
  localparam logic [1:0] QUAL_GOOD      = 2'd1;
  localparam logic [1:0] QUAL_FAIR      = 2'd2;
  localparam logic [1:0] QUAL_POOR      = 2'd3;

  // failure run saturation value
  localparam logic [LAT_W-1:0] STREAK_MAX = 16'hFFFF;

endpackage

// ----- src/lhm_ram.sv -----
// ----------------------------------------------------------------------------
// lhm_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lhm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/lhm_divider.sv -----
// ----------------------------------------------------------------------------
// lhm_divider: shared restoring divider
// Unsigned division, one quotient bit per cycle; done pulses for one cycle
// when the quotient is ready. The divisor must not be zero.
// ----------------------------------------------------------------------------
module lhm_divider #(
  parameter int unsigned DW = 22,
  parameter int unsigned VW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dsr_q, dsr_d;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          ge;

  // one restoring step
  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = shifted - {1'b0, dsr_q};
    ge      = (shifted >= {1'b0, dsr_q});
  end

  // sequencing of the steps
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[VW-1:0] : shifted[VW-1:0];
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- src/link_health_monitor.sv -----
// ----------------------------------------------------------------------------
// link_health_monitor: connectivity check statistics
// Keeps a latency window average, a loss window fraction and a failure run,
// grades link quality and flags recovery, loss and quality changes.
// ----------------------------------------------------------------------------
// Usage: one connectivity check is a request on the input channel
// (in_valid_i, in_stall_o, reachable_i, latency_ms_i). Each request gives
// exactly one result on the output channel (out_valid_o, out_stall_i).
// The thresholds are written through cfg_we_i, cfg_index_i and cfg_wdata_i
// while the block is idle; index 3 is ignored.
// Operation: a successful check runs two divisions on one
// shared bit-serial divider, a failed check only the loss division. With
// DW the divider width (the larger of the latency sum width and the loss
// dividend width, 22 bits at the default windows) each division yields DW
// quotient bits. A new request is taken only after the result of the
// last one has been loaded into the output register.
// In_stall_o is high from the accepting edge until the result is loaded
// into the output register. A stalled result holds; the next request may
// be taken meanwhile, and its result waits in the final step until the
// output register is free.
// Reset empties the windows, marks the latency average unknown, clears the failure run and sets the
// thresholds to 50, 100 and 200 ms; no clearing pass is needed.
// ----------------------------------------------------------------------------
module link_health_monitor #(
  parameter int unsigned LATENCY_WINDOW = lhm_pkg::LATENCY_WINDOW_DEF,
  parameter int unsigned LOSS_WINDOW    = lhm_pkg::LOSS_WINDOW_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [lhm_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [lhm_pkg::CFG_W-1:0]    cfg_wdata_i,
  // check requests
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         reachable_i,
  input  logic [lhm_pkg::LAT_W-1:0]    latency_ms_i,
  // results
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [16:0]           smoothed_latency_o,
  output logic [lhm_pkg::LOSS_W-1:0]   loss_fraction_o,
  output logic [lhm_pkg::LAT_W-1:0]    failure_run_o,
  output logic [1:0]                   quality_o,
  output logic                         recovered_o,
  output logic                         lost_o,
  output logic                         quality_changed_o
);

  import lhm_pkg::*;

  localparam int unsigned LAW    = (LATENCY_WINDOW > 1) ? $clog2(LATENCY_WINDOW) : 1;
  localparam int unsigned CAW    = (LOSS_WINDOW > 1) ? $clog2(LOSS_WINDOW) : 1;
  localparam int unsigned LCNT_W = $clog2(LATENCY_WINDOW + 1);
  localparam int unsigned CCNT_W = $clog2(LOSS_WINDOW + 1);
  localparam int unsigned SUM_W  = LAT_W + LCNT_W;
  localparam int unsigned LDIV_W = CCNT_W + FRAC_W;
  localparam int unsigned DW     = (SUM_W > LDIV_W) ? SUM_W : LDIV_W;
  localparam int unsigned VW     = (LCNT_W > CCNT_W) ? LCNT_W : CCNT_W;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_READ      = 7'b0000010,
    S_AVG_GO    = 7'b0000100,
    S_AVG_WAIT  = 7'b0001000,
    S_LOSS_GO   = 7'b0010000,
    S_LOSS_WAIT = 7'b0100000,
    S_GRADE     = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // thresholds
  logic [CFG_W-1:0] exc_q, good_q, fair_q;

  // window state
  logic [LAW-1:0]    lhead_q, lhead_d;
  logic [LCNT_W-1:0] lcount_q, lcount_d;
  logic [SUM_W-1:0]  lsum_q, lsum_d;
  logic [CAW-1:0]    chead_q, chead_d;
  logic [CCNT_W-1:0] ccount_q, ccount_d;
  logic [CCNT_W-1:0] fail_q, fail_d;
  logic [LAT_W-1:0]  streak_q, streak_d;
  logic              avg_known_q, avg_known_d;
  logic [LAT_W-1:0]  avg_q, avg_d;
  logic              prev_ok_q, prev_ok_d;
  logic [1:0]        last_grade_q, last_grade_d;

  // captured request and computed loss
  logic              ok_q;
  logic [LAT_W-1:0]  lat_q;
  logic [LOSS_W-1:0] loss_q, loss_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [16:0]       smooth_q;
  logic [LOSS_W-1:0] lossf_q;
  logic [LAT_W-1:0]  run_q;
  logic [1:0]        qual_q;
  logic              rec_q, lost_q, chg_q;
  logic              out_load;

  // memory and divider connections
  logic              lram_we, cram_we;
  logic [LAT_W-1:0]  lram_rdata;
  logic [0:0]        cram_rdata;
  logic              div_start;
  logic [DW-1:0]     div_dividend;
  logic [VW-1:0]     div_divisor;
  logic              div_done;
  logic [DW-1:0]     div_quot;

  logic              in_take;
  logic              lfull, cfull;
  logic              failed;
  logic [1:0]        grade;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && (state_q == S_IDLE);
  assign lfull      = (lcount_q == LCNT_W'(LATENCY_WINDOW));
  assign cfull      = (ccount_q == CCNT_W'(LOSS_WINDOW));
  assign failed     = !ok_q;

  // latency ring
  lhm_ram #(
    .WIDTH(LAT_W),
    .DEPTH(LATENCY_WINDOW)
  ) u_lat_ram (
    .clk_i  (clk_i),
    .we_i   (lram_we),
    .waddr_i(lhead_q),
    .wdata_i(lat_q),
    .raddr_i(lhead_q),
    .rdata_o(lram_rdata)
  );

  // check outcome ring, 1 = failed
  lhm_ram #(
    .WIDTH(1),
    .DEPTH(LOSS_WINDOW)
  ) u_chk_ram (
    .clk_i  (clk_i),
    .we_i   (cram_we),
    .waddr_i(chead_q),
    .wdata_i(failed),
    .raddr_i(chead_q),
    .rdata_o(cram_rdata)
  );

  // shared divider
  lhm_divider #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  // quality grade from the current check and window average
  always_comb begin
    if (!ok_q) begin
      grade = QUAL_POOR;
    end else if (!avg_known_q) begin
      grade = QUAL_FAIR;
    end else if (avg_q < exc_q) begin
      grade = QUAL_EXCELLENT;
    end else if (avg_q < good_q) begin
      grade = QUAL_GOOD;
    end else if (avg_q < fair_q) begin
      grade = QUAL_FAIR;
    end else begin
      grade = QUAL_POOR;
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    lhead_d      = lhead_q;
    lcount_d     = lcount_q;
    lsum_d       = lsum_q;
    chead_d      = chead_q;
    ccount_d     = ccount_q;
    fail_d       = fail_q;
    streak_d     = streak_q;
    avg_known_d  = avg_known_q;
    avg_d        = avg_q;
    prev_ok_d    = prev_ok_q;
    last_grade_d = last_grade_q;
    loss_d       = loss_q;
    lram_we      = 1'b0;
    cram_we      = 1'b0;
    div_start    = 1'b0;
    div_dividend = DW'(lsum_q);
    div_divisor  = VW'(lcount_q);
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        // ring read data of the head slots is valid here
        cram_we  = 1'b1;
        chead_d  = (chead_q == CAW'(LOSS_WINDOW - 1)) ? '0 : chead_q + 1'b1;
        if (!cfull) begin
          ccount_d = ccount_q + 1'b1;
        end
        fail_d = fail_q + CCNT_W'(failed) - CCNT_W'(cfull && cram_rdata[0]);
        if (ok_q) begin
          lram_we  = 1'b1;
          lhead_d  = (lhead_q == LAW'(LATENCY_WINDOW - 1)) ? '0 : lhead_q + 1'b1;
          if (!lfull) begin
            lcount_d = lcount_q + 1'b1;
          end
          lsum_d   = lsum_q + SUM_W'(lat_q) - (lfull ? SUM_W'(lram_rdata) : '0);
          streak_d = '0;
          state_d  = S_AVG_GO;
        end else begin
          if (streak_q != STREAK_MAX) begin
            streak_d = streak_q + 1'b1;
          end
          state_d = S_LOSS_GO;
        end
      end
      S_AVG_GO: begin
        div_start = 1'b1;
        state_d   = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (div_done) begin
          avg_known_d = 1'b1;
          avg_d       = div_quot[LAT_W-1:0];
          state_d     = S_LOSS_GO;
        end
      end
      S_LOSS_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'({fail_q, {FRAC_W{1'b0}}});
        div_divisor  = VW'(ccount_q);
        state_d      = S_LOSS_WAIT;
      end
      S_LOSS_WAIT: begin
        if (div_done) begin
          loss_d  = div_quot[LOSS_W-1:0];
          state_d = S_GRADE;
        end
      end
      S_GRADE: begin
        // wait for a free output register
        if (!out_valid_q || !out_stall_i) begin
          out_load     = 1'b1;
          prev_ok_d    = ok_q;
          last_grade_d = grade;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state and thresholds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      exc_q        <= EXCELLENT_RST;
      good_q       <= GOOD_RST;
      fair_q       <= FAIR_RST;
      lhead_q      <= '0;
      lcount_q     <= '0;
      lsum_q       <= '0;
      chead_q      <= '0;
      ccount_q     <= '0;
      fail_q       <= '0;
      streak_q     <= '0;
      avg_known_q  <= 1'b0;
      prev_ok_q    <= 1'b0;
      last_grade_q <= QUAL_FAIR;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      lhead_q      <= lhead_d;
      lcount_q     <= lcount_d;
      lsum_q       <= lsum_d;
      chead_q      <= chead_d;
      ccount_q     <= ccount_d;
      fail_q       <= fail_d;
      streak_q     <= streak_d;
      avg_known_q  <= avg_known_d;
      prev_ok_q    <= prev_ok_d;
      last_grade_q <= last_grade_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_EXCELLENT: exc_q  <= cfg_wdata_i;
          REG_GOOD:      good_q <= cfg_wdata_i;
          REG_FAIR:      fair_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    avg_q  <= avg_d;
    loss_q <= loss_d;
    if (in_take) begin
      ok_q  <= reachable_i;
      lat_q <= latency_ms_i;
    end
    if (out_load) begin
      smooth_q <= avg_known_q ? {1'b0, avg_q} : '1;
      lossf_q  <= loss_q;
      run_q    <= streak_q;
      qual_q   <= grade;
      rec_q    <= !prev_ok_q && ok_q;
      lost_q   <= prev_ok_q && !ok_q;
      chg_q    <= (grade != last_grade_q);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign smoothed_latency_o = signed'(smooth_q);
  assign loss_fraction_o    = lossf_q;
  assign failure_run_o      = run_q;
  assign quality_o          = qual_q;
  assign recovered_o        = rec_q;
  assign lost_o             = lost_q;
  assign quality_changed_o  = chg_q;

endmodule
